[hw/rtl/i2cmbe_pkg.sv]
`timescale 1ns / 1ps

package i2cmbe_pkg;

    localparam int TDATA_IN_W  = 16;
    localparam int TUSER_IN_W  = 3;
    localparam int TDATA_OUT_W = 16;
    localparam int CFG_IDX_W   = 8;
    localparam int CFG_DATA_W  = 16;

    localparam logic [CFG_IDX_W-1:0] REG_HALF_PERIOD = 8'd0;
    localparam logic [CFG_IDX_W-1:0] REG_ACK_TIMEOUT = 8'd1;

    localparam logic [15:0] HALF_PERIOD_RST = 16'd2;
    localparam logic [7:0]  ACK_TIMEOUT_RST = 8'd250;

    // raw op codes on the input stream
    localparam logic [2:0] OP_TICK  = 3'd0;
    localparam logic [2:0] OP_START = 3'd1;
    localparam logic [2:0] OP_STOP  = 3'd2;
    localparam logic [2:0] OP_WRITE = 3'd3;
    localparam logic [2:0] OP_READ  = 3'd4;
    localparam logic [2:0] OP_WAIT  = 3'd5;

    typedef enum logic [2:0] {
        CMD_NONE,
        CMD_START,
        CMD_STOP,
        CMD_WRITE,
        CMD_READ,
        CMD_WAIT_ACK
    } cmd_t;

    typedef struct packed {
        cmd_t       cmd;
        logic [7:0] tx_byte;
        logic       send_ack;
        logic       sda_in;
    } cmd_item_t;

    typedef struct packed {
        logic       nack;
        logic [7:0] rx_byte;
        logic       done_res;
        logic       busy_res;
        logic       sda_release;
        logic       scl_level;
    } result_t;

    typedef struct packed {
        logic      valid;
        cmd_item_t item;
    } queue_head_t;

endpackage

[hw/rtl/i2cmbe_front.sv]
`timescale 1ns / 1ps

module i2cmbe_front (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              s_tvalid,
    output logic                              s_tready,
    input  logic [i2cmbe_pkg::TDATA_IN_W-1:0] s_tdata,
    input  logic [i2cmbe_pkg::TUSER_IN_W-1:0] s_tuser,
    output i2cmbe_pkg::queue_head_t           q_head,
    input  logic                              q_pop
);
    import i2cmbe_pkg::*;

    logic [1:0] cnt_reg;
    logic [1:0] cnt_next;
    cmd_item_t  head_reg;
    cmd_item_t  tail_reg;
    cmd_item_t  in_item;
    logic       push;

    // classify the op code; unused codes behave as a bare tick
    always_comb begin
        case (s_tuser)
            OP_START: in_item.cmd = CMD_START;
            OP_STOP:  in_item.cmd = CMD_STOP;
            OP_WRITE: in_item.cmd = CMD_WRITE;
            OP_READ:  in_item.cmd = CMD_READ;
            OP_WAIT:  in_item.cmd = CMD_WAIT_ACK;
            default:  in_item.cmd = CMD_NONE;
        endcase
        in_item.tx_byte  = s_tdata[7:0];
        in_item.send_ack = s_tdata[8];
        in_item.sda_in   = s_tdata[9];
    end

    assign s_tready = (cnt_reg != 2'd2);
    assign push     = s_tvalid && s_tready;
    assign cnt_next = cnt_reg + {1'b0, push} - {1'b0, q_pop};

    assign q_head.valid = (cnt_reg != 2'd0);
    assign q_head.item  = head_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg <= 2'd0;
        end else begin
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (q_pop) begin
            if (cnt_reg == 2'd2) begin
                head_reg <= tail_reg;
            end else if (push) begin
                head_reg <= in_item;
            end
        end else if (push) begin
            if (cnt_reg == 2'd0) begin
                head_reg <= in_item;
            end else begin
                tail_reg <= in_item;
            end
        end
    end

endmodule

[hw/rtl/i2cmbe_seq.sv]
`timescale 1ns / 1ps

module i2cmbe_seq (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  i2cmbe_pkg::queue_head_t            q_head,
    output logic                               q_pop,
    input  logic [15:0]                        half_period,
    input  logic [7:0]                         ack_timeout,
    output logic                               m_tvalid,
    input  logic                               m_tready,
    output logic [i2cmbe_pkg::TDATA_OUT_W-1:0] m_tdata
);
    import i2cmbe_pkg::*;

    typedef enum logic [3:0] {
        PH_IDLE,
        PH_STA_HI,
        PH_STA_LO,
        PH_STO_LO,
        PH_STO_HI,
        PH_WR_LOW,
        PH_WR_HIGH,
        PH_RD_LOW,
        PH_RD_HIGH,
        PH_AK_LOW,
        PH_AK_HIGH,
        PH_WAIT
    } phase_t;

    phase_t      phase_reg, phase_next;
    logic [15:0] tick_reg, tick_next;
    logic [3:0]  bit_reg, bit_next;
    logic [7:0]  shift_reg, shift_next;
    logic [7:0]  wait_reg, wait_next;
    logic        scl_reg, scl_next;
    logic        sda_reg, sda_next;
    logic        ack_choice_reg, ack_choice_next;
    logic        nack_reg, nack_next;
    logic [7:0]  rx_reg, rx_next;
    logic        done;
    logic        m_valid_reg;
    result_t     res_reg;
    result_t     res_next;

    cmd_item_t   item;
    logic [15:0] hp;
    logic        seg_end;
    logic [3:0]  bit_inc;
    logic [7:0]  shift_wr;
    logic [7:0]  shift_rd;

    assign item     = q_head.item;
    assign q_pop    = q_head.valid && (!m_valid_reg || m_tready);
    assign hp       = (half_period == 16'd0) ? 16'd1 : half_period;
    assign seg_end  = ({1'b0, tick_reg} + 17'd1) >= {1'b0, hp};
    assign bit_inc  = bit_reg + 4'd1;
    assign shift_wr = {shift_reg[6:0], 1'b0};
    assign shift_rd = {shift_reg[6:0], item.sda_in};

    always_comb begin
        phase_next      = phase_reg;
        tick_next       = tick_reg;
        bit_next        = bit_reg;
        shift_next      = shift_reg;
        wait_next       = wait_reg;
        scl_next        = scl_reg;
        sda_next        = sda_reg;
        ack_choice_next = ack_choice_reg;
        nack_next       = nack_reg;
        rx_next         = rx_reg;
        done            = 1'b0;

        if (phase_reg == PH_IDLE) begin
            bit_next = 4'd0;
            case (item.cmd)
                CMD_START: begin
                    phase_next = PH_STA_HI;
                    tick_next  = 16'd0;
                    scl_next   = 1'b1;
                    sda_next   = 1'b1;
                end
                CMD_STOP: begin
                    phase_next = PH_STO_LO;
                    tick_next  = 16'd0;
                    scl_next   = 1'b0;
                    sda_next   = 1'b0;
                end
                CMD_WRITE: begin
                    shift_next = item.tx_byte;
                    phase_next = PH_WR_LOW;
                    tick_next  = 16'd0;
                    scl_next   = 1'b0;
                    sda_next   = item.tx_byte[7];
                end
                CMD_READ: begin
                    shift_next      = 8'd0;
                    ack_choice_next = item.send_ack;
                    phase_next      = PH_RD_LOW;
                    tick_next       = 16'd0;
                    scl_next        = 1'b0;
                    sda_next        = 1'b1;
                end
                CMD_WAIT_ACK: begin
                    wait_next  = 8'd0;
                    nack_next  = 1'b0;
                    phase_next = PH_WAIT;
                    tick_next  = 16'd0;
                    scl_next   = 1'b1;
                    sda_next   = 1'b1;
                end
                default: ;
            endcase
        end else if (phase_reg == PH_WAIT) begin
            if (!item.sda_in) begin
                phase_next = PH_IDLE;
                tick_next  = 16'd0;
                bit_next   = 4'd0;
                scl_next   = 1'b0;
                done       = 1'b1;
            end else if (wait_reg >= ack_timeout) begin
                // timed out: flag it and run a stop
                nack_next  = 1'b1;
                bit_next   = 4'd0;
                phase_next = PH_STO_LO;
                tick_next  = 16'd0;
                scl_next   = 1'b0;
                sda_next   = 1'b0;
            end else begin
                wait_next = wait_reg + 8'd1;
            end
        end else if (seg_end) begin
            case (phase_reg)
                PH_STA_HI: begin
                    if (bit_reg == 4'd0) begin
                        bit_next  = 4'd1;
                        tick_next = 16'd0;
                    end else begin
                        bit_next   = 4'd0;
                        phase_next = PH_STA_LO;
                        tick_next  = 16'd0;
                        scl_next   = 1'b1;
                        sda_next   = 1'b0;
                    end
                end
                PH_STA_LO: begin
                    if (bit_reg == 4'd0) begin
                        bit_next  = 4'd1;
                        tick_next = 16'd0;
                    end else begin
                        phase_next = PH_IDLE;
                        tick_next  = 16'd0;
                        bit_next   = 4'd0;
                        scl_next   = 1'b0;
                        done       = 1'b1;
                    end
                end
                PH_STO_LO: begin
                    if (bit_reg == 4'd0) begin
                        bit_next  = 4'd1;
                        tick_next = 16'd0;
                    end else begin
                        bit_next   = 4'd0;
                        phase_next = PH_STO_HI;
                        tick_next  = 16'd0;
                        scl_next   = 1'b1;
                        sda_next   = 1'b1;
                    end
                end
                PH_STO_HI: begin
                    if (bit_reg == 4'd0) begin
                        bit_next  = 4'd1;
                        tick_next = 16'd0;
                    end else begin
                        // bus left released after the stop
                        phase_next = PH_IDLE;
                        tick_next  = 16'd0;
                        bit_next   = 4'd0;
                        scl_next   = 1'b1;
                        done       = 1'b1;
                    end
                end
                PH_WR_LOW: begin
                    phase_next = PH_WR_HIGH;
                    tick_next  = 16'd0;
                    scl_next   = 1'b1;
                end
                PH_WR_HIGH: begin
                    shift_next = shift_wr;
                    tick_next  = 16'd0;
                    if (bit_inc >= 4'd8) begin
                        phase_next = PH_IDLE;
                        bit_next   = 4'd0;
                        scl_next   = 1'b0;
                        done       = 1'b1;
                    end else begin
                        bit_next   = bit_inc;
                        phase_next = PH_WR_LOW;
                        scl_next   = 1'b0;
                        sda_next   = shift_reg[6];
                    end
                end
                PH_RD_LOW: begin
                    phase_next = PH_RD_HIGH;
                    tick_next  = 16'd0;
                    scl_next   = 1'b1;
                    sda_next   = 1'b1;
                end
                PH_RD_HIGH: begin
                    shift_next = shift_rd;
                    tick_next  = 16'd0;
                    scl_next   = 1'b0;
                    if (bit_inc >= 4'd8) begin
                        bit_next   = 4'd0;
                        rx_next    = shift_rd;
                        phase_next = PH_AK_LOW;
                        sda_next   = ~ack_choice_reg;
                    end else begin
                        bit_next   = bit_inc;
                        phase_next = PH_RD_LOW;
                        sda_next   = 1'b1;
                    end
                end
                PH_AK_LOW: begin
                    phase_next = PH_AK_HIGH;
                    tick_next  = 16'd0;
                    scl_next   = 1'b1;
                end
                PH_AK_HIGH: begin
                    phase_next = PH_IDLE;
                    tick_next  = 16'd0;
                    bit_next   = 4'd0;
                    scl_next   = 1'b0;
                    done       = 1'b1;
                end
                default: begin
                    phase_next = PH_IDLE;
                    tick_next  = 16'd0;
                    bit_next   = 4'd0;
                end
            endcase
        end else begin
            tick_next = tick_reg + 16'd1;
        end

        res_next.scl_level   = scl_next;
        res_next.sda_release = sda_next;
        res_next.busy_res    = (phase_next != PH_IDLE);
        res_next.done_res    = done;
        res_next.rx_byte     = rx_next;
        res_next.nack        = nack_next;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg      <= PH_IDLE;
            tick_reg       <= 16'd0;
            bit_reg        <= 4'd0;
            shift_reg      <= 8'd0;
            wait_reg       <= 8'd0;
            scl_reg        <= 1'b1;
            sda_reg        <= 1'b1;
            ack_choice_reg <= 1'b0;
            nack_reg       <= 1'b0;
            rx_reg         <= 8'd0;
            m_valid_reg    <= 1'b0;
        end else begin
            if (q_pop) begin
                phase_reg      <= phase_next;
                tick_reg       <= tick_next;
                bit_reg        <= bit_next;
                shift_reg      <= shift_next;
                wait_reg       <= wait_next;
                scl_reg        <= scl_next;
                sda_reg        <= sda_next;
                ack_choice_reg <= ack_choice_next;
                nack_reg       <= nack_next;
                rx_reg         <= rx_next;
                res_reg        <= res_next;
                m_valid_reg    <= 1'b1;
            end else if (m_tready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {{(TDATA_OUT_W - $bits(result_t)){1'b0}}, res_reg};

endmodule

[hw/rtl/i2c_master_bit_engine_core.sv]
`timescale 1ns / 1ps
// Channel  | Direction | Handshake            | Payload
// s_       | in        | s_tvalid / s_tready  | s_tdata, s_tuser (one bus tick)
// m_       | out       | m_tvalid / m_tready  | m_tdata (line levels and status)
// cfg_     | in        | cfg_valid / cfg_ready| cfg_index, cfg_data
//
// One word in and one word out per clock unless a side stalls; the sequencer's next
// state is combinational, so the tick rate is set by nothing but the handshakes.
// A word lands in the two-entry queue, then the sequencer turns it into the
// output register.
// Either side may stall; the queue absorbs two words before s_tready drops.
// Reset (aresetn, synchronous) leaves the bus released and the engine idle.

module i2c_master_bit_engine_core (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               s_tvalid,
    output logic                               s_tready,
    // tx_byte[7:0], send_ack[8], sda_in[9], zero fill
    input  logic [i2cmbe_pkg::TDATA_IN_W-1:0]  s_tdata,
    // op[2:0]
    input  logic [i2cmbe_pkg::TUSER_IN_W-1:0]  s_tuser,
    output logic                               m_tvalid,
    input  logic                               m_tready,
    // scl_level[0], sda_release[1], busy_res[2], done_res[3], rx_byte[11:4],
    // nack[12], zero fill
    output logic [i2cmbe_pkg::TDATA_OUT_W-1:0] m_tdata,
    input  logic                               cfg_valid,
    output logic                               cfg_ready,
    input  logic [i2cmbe_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [i2cmbe_pkg::CFG_DATA_W-1:0]  cfg_data
);
    import i2cmbe_pkg::*;

    logic [15:0] half_period_reg;
    logic [7:0]  ack_timeout_reg;
    queue_head_t q_head;
    logic        q_pop;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            half_period_reg <= HALF_PERIOD_RST;
            ack_timeout_reg <= ACK_TIMEOUT_RST;
        end else if (cfg_valid && cfg_ready) begin
            // drop writes to unknown indexes
            if (cfg_index == REG_HALF_PERIOD) begin
                half_period_reg <= cfg_data;
            end else if (cfg_index == REG_ACK_TIMEOUT) begin
                ack_timeout_reg <= cfg_data[7:0];
            end
        end
    end

    i2cmbe_front u_front (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .q_head   (q_head),
        .q_pop    (q_pop)
    );

    i2cmbe_seq u_seq (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .q_head      (q_head),
        .q_pop       (q_pop),
        .half_period (half_period_reg),
        .ack_timeout (ack_timeout_reg),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata)
    );

endmodule

[hw/rtl/i2cmbe_checker.sv]
`timescale 1ns / 1ps

module i2cmbe_checker (
    input logic                               aclk,
    input logic                               aresetn,
    input logic                               m_tvalid,
    input logic                               m_tready,
    input logic [i2cmbe_pkg::TDATA_OUT_W-1:0] m_tdata
);
    import i2cmbe_pkg::*;

    // output register empties on reset
    a_reset_empty: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("m_tvalid high after reset");

    a_hold_stalled: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("stalled output word changed");

    // a finishing command always leaves the engine idle
    a_done_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tdata[3] |-> !m_tdata[2])
        else $error("done reported while busy");

    // only a stop finishes with SCL high, and it leaves SDA released
    a_stop_release: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tdata[3] && m_tdata[0] |-> m_tdata[1])
        else $error("command ended with SCL high and SDA low");

endmodule

bind i2c_master_bit_engine_core i2cmbe_checker u_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);
